>>> hw/rtl/bll_pkg.sv
// bll_pkg: constants, types and microcode table of the binary lifting lca block
`timescale 1ns / 1ps
package bll_pkg;

  localparam int MAX_NODES = 1024;
  localparam int TOP_LEVEL = 10;
  localparam int LEVELS    = TOP_LEVEL + 1;
  localparam int NODE_W    = 10;
  localparam int DEPTH_W   = 10;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ANC_DEPTH = MAX_NODES * LEVELS;
  localparam int ANC_AW    = $clog2(ANC_DEPTH);
  localparam int UPC_W     = 5;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [ANC_AW-1:0]  anc_addr_t;
  typedef logic [UPC_W-1:0]   upc_t;

  localparam depth_t DEPTH_MAX = {DEPTH_W{1'b1}};
  localparam lvl_t   LVL_TOP   = lvl_t'(TOP_LEVEL);
  localparam lvl_t   LVL_LAST  = lvl_t'(TOP_LEVEL - 1);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  // datapath action of one microcode step
  typedef enum logic [3:0] {
    U_IDLE,
    U_NOP,
    U_RD_DEP_A,
    U_RD_DEP_B,
    U_INS_START,
    U_RD_CUR,
    U_INS_STEP,
    U_SWAP,
    U_L1_UP,
    U_L1_CMP,
    U_L2_START,
    U_L2_STEP,
    U_RD_PARENT,
    U_OUT_ANC,
    U_OUT_A
  } uop_e;

  // jump condition of one microcode step
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_QUERY,
    C_SAME,
    C_LVL_UP,
    C_LVL_DOWN
  } cond_e;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    upc_t  target;
  } ctrl_t;

  localparam upc_t UPC_IDLE       = upc_t'(0);
  localparam upc_t UPC_DISPATCH   = upc_t'(1);
  localparam upc_t UPC_INS_DEPTH  = upc_t'(2);
  localparam upc_t UPC_INS_START  = upc_t'(3);
  localparam upc_t UPC_INS_READ   = upc_t'(4);
  localparam upc_t UPC_INS_STEP   = upc_t'(5);
  localparam upc_t UPC_INS_END    = upc_t'(6);
  localparam upc_t UPC_Q_DEP_A    = upc_t'(7);
  localparam upc_t UPC_Q_DEP_B    = upc_t'(8);
  localparam upc_t UPC_Q_SWAP     = upc_t'(9);
  localparam upc_t UPC_L1_UP      = upc_t'(10);
  localparam upc_t UPC_L1_CMP     = upc_t'(11);
  localparam upc_t UPC_L2_START   = upc_t'(12);
  localparam upc_t UPC_L2_STEP    = upc_t'(13);
  localparam upc_t UPC_RD_PARENT  = upc_t'(14);
  localparam upc_t UPC_OUT_ANC    = upc_t'(15);
  localparam upc_t UPC_OUT_A      = upc_t'(16);
  localparam upc_t UPC_LAST       = UPC_OUT_A;

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    unique case (pc)
      UPC_IDLE:      w = '{uop: U_IDLE,      cond: C_NO_ACCEPT, target: UPC_IDLE};
      UPC_DISPATCH:  w = '{uop: U_NOP,       cond: C_QUERY,     target: UPC_Q_DEP_A};
      UPC_INS_DEPTH: w = '{uop: U_RD_DEP_B,  cond: C_NEXT,      target: UPC_IDLE};
      UPC_INS_START: w = '{uop: U_INS_START, cond: C_NEXT,      target: UPC_IDLE};
      UPC_INS_READ:  w = '{uop: U_RD_CUR,    cond: C_NEXT,      target: UPC_IDLE};
      UPC_INS_STEP:  w = '{uop: U_INS_STEP,  cond: C_LVL_UP,    target: UPC_INS_READ};
      UPC_INS_END:   w = '{uop: U_NOP,       cond: C_ALWAYS,    target: UPC_IDLE};
      UPC_Q_DEP_A:   w = '{uop: U_RD_DEP_A,  cond: C_SAME,      target: UPC_OUT_A};
      UPC_Q_DEP_B:   w = '{uop: U_RD_DEP_B,  cond: C_NEXT,      target: UPC_IDLE};
      UPC_Q_SWAP:    w = '{uop: U_SWAP,      cond: C_NEXT,      target: UPC_IDLE};
      UPC_L1_UP:     w = '{uop: U_L1_UP,     cond: C_NEXT,      target: UPC_IDLE};
      UPC_L1_CMP:    w = '{uop: U_L1_CMP,    cond: C_LVL_DOWN,  target: UPC_L1_UP};
      UPC_L2_START:  w = '{uop: U_L2_START,  cond: C_SAME,      target: UPC_OUT_A};
      UPC_L2_STEP:   w = '{uop: U_L2_STEP,   cond: C_LVL_DOWN,  target: UPC_L2_STEP};
      UPC_RD_PARENT: w = '{uop: U_RD_PARENT, cond: C_NEXT,      target: UPC_IDLE};
      UPC_OUT_ANC:   w = '{uop: U_OUT_ANC,   cond: C_ALWAYS,    target: UPC_IDLE};
      UPC_OUT_A:     w = '{uop: U_OUT_A,     cond: C_ALWAYS,    target: UPC_IDLE};
      default:       w = '{uop: U_NOP,       cond: C_ALWAYS,    target: UPC_IDLE};
    endcase
    return w;
  endfunction

  // row-major ancestor store: one row of LEVELS entries per node
  function automatic anc_addr_t anc_addr(node_t node, lvl_t lvl);
    return anc_addr_t'(node) * anc_addr_t'(LEVELS) + anc_addr_t'(lvl);
  endfunction

endpackage

>>> hw/rtl/bll_ram.sv
// bll_ram: generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps
module bll_ram #(
  parameter int Width = 10,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/binary_lifting_lca.sv
// binary_lifting_lca: microcoded lowest common ancestor store with binary lifting
// insert: depth read, depth and level 0 write, then a read and a write step per ancestor level
// query: depth reads, swap, depth pass, ancestor pass, parent read, result; next request at idle
//   a is output after the depth pass if it meets, or at once if both nodes are equal
// a result waiting on out_ready_i holds the sequencer at its output step
// reset clears sequencer and datapath registers; the rams stay uncleared, no clearing pass
`timescale 1ns / 1ps
module binary_lifting_lca
  import bll_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NODE_W-1:0] ancestor_node_o
);

  ctrl_t  ctrl;
  logic   in_fire;
  logic   stall;
  logic   taken;

  upc_t   upc_q, upc_d;
  kind_e  kind_q, kind_d;
  node_t  a_q, a_d;
  node_t  b_q, b_d;
  node_t  up_q, up_d;
  node_t  cur_q, cur_d;
  depth_t da_q, da_d;
  lvl_t   lvl_q, lvl_d;
  node_t  res_q, res_d;
  logic   out_valid_q, out_valid_d;

  logic      dep_we, dep_re;
  node_t     dep_waddr, dep_raddr;
  depth_t    dep_wdata, dep_rdata;
  logic      anc_we, anc0_re, anc1_re;
  anc_addr_t anc_waddr, anc0_raddr, anc1_raddr;
  node_t     anc_wdata, anc0_rdata, anc1_rdata;

  node_t  a_n, b_n;
  depth_t db;

  assign ctrl        = ucode(upc_q);
  assign in_ready_o  = (upc_q == UPC_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign stall       = (ctrl.uop == U_OUT_ANC || ctrl.uop == U_OUT_A) &&
                       out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign ancestor_node_o = res_q;

  // sequencer: jump or step, hold while a result cannot be placed
  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_ACCEPT: taken = !in_fire;
      C_QUERY:     taken = (kind_q == KIND_QUERY);
      C_SAME:      taken = (a_q == b_q);
      C_LVL_UP:    taken = (lvl_q != LVL_LAST);
      C_LVL_DOWN:  taken = (lvl_q != '0);
      default:     taken = 1'b0;
    endcase
    if (stall) begin
      upc_d = upc_q;
    end else if (taken) begin
      upc_d = ctrl.target;
    end else begin
      upc_d = upc_q + upc_t'(1);
    end
  end

  // datapath driven by the current control word
  always_comb begin
    kind_d      = kind_q;
    a_d         = a_q;
    b_d         = b_q;
    up_d        = up_q;
    cur_d       = cur_q;
    da_d        = da_q;
    lvl_d       = lvl_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dep_we      = 1'b0;
    dep_waddr   = a_q;
    dep_wdata   = '0;
    dep_re      = 1'b0;
    dep_raddr   = a_q;
    anc_we      = 1'b0;
    anc_waddr   = anc_addr(a_q, lvl_q);
    anc_wdata   = b_q;
    anc0_re     = 1'b0;
    anc0_raddr  = anc_addr(a_q, lvl_q);
    anc1_re     = 1'b0;
    anc1_raddr  = anc_addr(b_q, lvl_q);
    a_n         = a_q;
    b_n         = b_q;
    db          = dep_rdata;
    unique case (ctrl.uop)
      U_IDLE: begin
        if (in_fire) begin
          kind_d = kind_e'(kind_i);
          a_d    = node_a_i;
          b_d    = node_b_i;
        end
      end
      U_NOP: begin
      end
      U_RD_DEP_A: begin
        dep_re    = 1'b1;
        dep_raddr = a_q;
      end
      U_RD_DEP_B: begin
        dep_re    = 1'b1;
        dep_raddr = b_q;
        da_d      = dep_rdata;
      end
      U_INS_START: begin
        dep_we    = 1'b1;
        dep_waddr = a_q;
        if (a_q == b_q) begin
          dep_wdata = '0;
        end else if (dep_rdata == DEPTH_MAX) begin
          dep_wdata = DEPTH_MAX;
        end else begin
          dep_wdata = dep_rdata + depth_t'(1);
        end
        // a root names itself as parent, so level 0 holds the node itself
        anc_we    = 1'b1;
        anc_waddr = anc_addr(a_q, '0);
        anc_wdata = b_q;
        cur_d     = b_q;
        lvl_d     = '0;
      end
      U_RD_CUR: begin
        anc0_re    = 1'b1;
        anc0_raddr = anc_addr(cur_q, lvl_q);
      end
      U_INS_STEP: begin
        lvl_d     = lvl_q + lvl_t'(1);
        anc_we    = 1'b1;
        anc_waddr = anc_addr(a_q, lvl_q + lvl_t'(1));
        anc_wdata = anc0_rdata;
        cur_d     = anc0_rdata;
      end
      U_SWAP: begin
        // keep the shallower node in a and its depth in da
        if (da_q > db) begin
          a_n  = b_q;
          b_n  = a_q;
          da_d = db;
        end
        a_d        = a_n;
        b_d        = b_n;
        lvl_d      = LVL_TOP;
        anc1_re    = 1'b1;
        anc1_raddr = anc_addr(b_n, LVL_TOP);
      end
      U_L1_UP: begin
        up_d      = anc1_rdata;
        dep_re    = 1'b1;
        dep_raddr = anc1_rdata;
      end
      U_L1_CMP: begin
        if (dep_rdata >= da_q) begin
          b_n = up_q;
        end
        b_d = b_n;
        if (lvl_q != '0) begin
          lvl_d      = lvl_q - lvl_t'(1);
          anc1_re    = 1'b1;
          anc1_raddr = anc_addr(b_n, lvl_q - lvl_t'(1));
        end
      end
      U_L2_START: begin
        lvl_d      = LVL_TOP;
        anc0_re    = 1'b1;
        anc0_raddr = anc_addr(a_q, LVL_TOP);
        anc1_re    = 1'b1;
        anc1_raddr = anc_addr(b_q, LVL_TOP);
      end
      U_L2_STEP: begin
        if (anc0_rdata != anc1_rdata) begin
          a_n = anc0_rdata;
          b_n = anc1_rdata;
        end
        a_d = a_n;
        b_d = b_n;
        if (lvl_q != '0) begin
          lvl_d      = lvl_q - lvl_t'(1);
          anc0_re    = 1'b1;
          anc0_raddr = anc_addr(a_n, lvl_q - lvl_t'(1));
          anc1_re    = 1'b1;
          anc1_raddr = anc_addr(b_n, lvl_q - lvl_t'(1));
        end
      end
      U_RD_PARENT: begin
        anc0_re    = 1'b1;
        anc0_raddr = anc_addr(a_q, '0);
      end
      U_OUT_ANC: begin
        if (!stall) begin
          res_d       = anc0_rdata;
          out_valid_d = 1'b1;
        end
      end
      U_OUT_A: begin
        if (!stall) begin
          res_d       = a_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UPC_IDLE;
      kind_q      <= KIND_INSERT;
      a_q         <= '0;
      b_q         <= '0;
      up_q        <= '0;
      cur_q       <= '0;
      da_q        <= '0;
      lvl_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      kind_q      <= kind_d;
      a_q         <= a_d;
      b_q         <= b_d;
      up_q        <= up_d;
      cur_q       <= cur_d;
      da_q        <= da_d;
      lvl_q       <= lvl_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  bll_ram #(
    .Width(DEPTH_W),
    .Depth(MAX_NODES)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .re_i    (dep_re),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  // two copies of the ancestor rows so both lifted nodes read in the same cycle
  bll_ram #(
    .Width(NODE_W),
    .Depth(ANC_DEPTH)
  ) u_anc0_ram (
    .clk_i   (clk_i),
    .we_i    (anc_we),
    .waddr_i (anc_waddr),
    .wdata_i (anc_wdata),
    .re_i    (anc0_re),
    .raddr_i (anc0_raddr),
    .rdata_o (anc0_rdata)
  );

  bll_ram #(
    .Width(NODE_W),
    .Depth(ANC_DEPTH)
  ) u_anc1_ram (
    .clk_i   (clk_i),
    .we_i    (anc_we),
    .waddr_i (anc_waddr),
    .wdata_i (anc_wdata),
    .re_i    (anc1_re),
    .raddr_i (anc1_raddr),
    .rdata_o (anc1_rdata)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> upc_q == UPC_DISPATCH)
    else $error("accepted request did not reach dispatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= UPC_LAST)
    else $error("microcode counter left the program");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LVL_TOP)
    else $error("lifting level out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (anc_we || dep_we) |-> kind_q == KIND_INSERT)
    else $error("table write during a query");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |->
      ($past(upc_q) == UPC_OUT_ANC || $past(upc_q) == UPC_OUT_A))
    else $error("result raised outside an output step");
`endif

endmodule
